[hdl/als_pkg.sv]
// shared types and constants for the addressable led serializer
`default_nettype none

package als_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_FILL  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_LATCH = 2'd3;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH        = 3'd6;

    localparam logic [7:0]  RST_BRIGHTNESS   = 8'd255;
    localparam logic [10:0] RST_STRIP_LENGTH = 11'd1024;
    localparam logic [7:0]  RST_ZERO_HIGH    = 8'd2;
    localparam logic [7:0]  RST_ZERO_LOW     = 8'd5;
    localparam logic [7:0]  RST_ONE_HIGH     = 8'd5;
    localparam logic [7:0]  RST_ONE_LOW      = 8'd2;
    localparam logic [15:0] RST_LATCH        = 16'd80;

    localparam int unsigned PIXEL_W = 24;

    typedef struct packed {
        logic accept;
        logic clear_we;
        logic fill_we;
        logic sweep_inc;
        logic load_byte;
    } ctrl_cmd_t;

    typedef struct packed {
        logic fill_go;
        logic load_go;
        logic clear_last;
        logic fill_last;
    } dp_stat_t;

endpackage

`default_nettype wire

[hdl/als_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module als_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/als_ctrl.sv]
// controller: handshake, clearing pass, fill sweep and byte load sequencing
`default_nettype none

module als_ctrl
    import als_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FILL  = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_RUN) && out_free;
    assign accept   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.accept    = accept;
        cmd.clear_we  = (state_reg == ST_CLEAR);
        cmd.fill_we   = (state_reg == ST_FILL);
        cmd.sweep_inc = (state_reg == ST_CLEAR) || (state_reg == ST_FILL);
        cmd.load_byte = (state_reg == ST_LOAD);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept && stat.fill_go)
                begin
                    state_next = ST_FILL;
                end
                else if (accept && stat.load_go)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_FILL:
            begin
                if (stat.fill_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[hdl/als_datapath.sv]
// datapath: config registers, pixel store, serializer state and result registers
`default_nettype none

module als_datapath
    import als_pkg::*;
#(
    parameter int MAX_LEDS = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [1:0]            action,
    input  wire logic [9:0]            pixel_index,
    input  wire logic [7:0]            red,
    input  wire logic [7:0]            green,
    input  wire logic [7:0]            blue,
    input  wire ctrl_cmd_t             cmd,
    output dp_stat_t                   stat,
    output logic                       data_line,
    output logic                       busy_res,
    output logic                       frame_done
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int LW = $clog2(MAX_LEDS + 1);
    localparam int CW = (LW > 11) ? LW : 11;

    logic [7:0]  bright_reg;
    logic [10:0] strip_reg;
    logic [7:0]  zero_high_reg;
    logic [7:0]  zero_low_reg;
    logic [7:0]  one_high_reg;
    logic [7:0]  one_low_reg;
    logic [15:0] latch_reg;

    logic [1:0]    phase_reg,  phase_next;
    logic [15:0]   count_reg,  count_next;
    logic [2:0]    bit_reg,    bit_next;
    logic [1:0]    chan_reg,   chan_next;
    logic [LW-1:0] pix_reg,    pix_next;
    logic [7:0]    shift_reg;
    logic [AW-1:0] sweep_reg;
    logic [PIXEL_W-1:0] fill_color_reg;

    logic line_reg;
    logic busy_reg;
    logic done_reg;

    logic [CW-1:0] len;
    logic [CW-1:0] len_m1;
    logic [CW-1:0] idx_ext;
    logic [15:0]   cnt_inc;
    logic [LW-1:0] pix_inc;
    logic [LW-1:0] pix_cand;
    logic          cur_bit;
    logic [7:0]    hi_sel, lo_sel, hi_lim, lo_lim;
    logic [15:0]   latch_lim;
    logic          load_go;
    logic          fill_go;
    logic          wr_pixel;
    logic          done;
    logic          line;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [PIXEL_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [PIXEL_W-1:0]  ram_rdata;

    logic [7:0]  chan_val;
    logic [15:0] prod;
    logic [16:0] quot_sum;
    logic [7:0]  scaled;

    assign len = (CW'(strip_reg) > CW'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(strip_reg);
    assign len_m1  = len - CW'(1);
    assign idx_ext = CW'(pixel_index);
    assign cnt_inc = count_reg + 16'd1;
    assign pix_inc = pix_reg + LW'(1);
    assign cur_bit = shift_reg[bit_reg];
    assign hi_sel  = cur_bit ? one_high_reg : zero_high_reg;
    assign lo_sel  = cur_bit ? one_low_reg : zero_low_reg;
    assign hi_lim  = (hi_sel == 8'd0) ? 8'd1 : hi_sel;
    assign lo_lim  = (lo_sel == 8'd0) ? 8'd1 : lo_sel;
    assign latch_lim = (latch_reg == 16'd0) ? 16'd1 : latch_reg;
    assign pix_cand  = (chan_reg == 2'd2) ? pix_inc : pix_reg;

    // serializer next state for one transfer
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        bit_next   = bit_reg;
        chan_next  = chan_reg;
        pix_next   = pix_reg;
        load_go    = 1'b0;
        fill_go    = 1'b0;
        wr_pixel   = 1'b0;
        done       = 1'b0;
        line       = 1'b0;
        if (action != ACT_TICK)
        begin
            if (phase_reg == PH_IDLE)
            begin
                case (action)
                    ACT_WRITE:
                    begin
                        wr_pixel = (idx_ext < len);
                    end
                    ACT_FILL:
                    begin
                        fill_go = (len != CW'(0));
                    end
                    ACT_START:
                    begin
                        pix_next   = '0;
                        chan_next  = 2'd0;
                        count_next = 16'd0;
                        if (len == CW'(0))
                        begin
                            phase_next = PH_LATCH;
                        end
                        else
                        begin
                            bit_next   = 3'd7;
                            phase_next = PH_HIGH;
                            load_go    = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            line = (phase_next == PH_HIGH);
        end
        else
        begin
            case (phase_reg)
                PH_HIGH:
                begin
                    line = 1'b1;
                    if (cnt_inc >= {8'd0, hi_lim})
                    begin
                        phase_next = PH_LOW;
                        count_next = 16'd0;
                    end
                    else
                    begin
                        count_next = cnt_inc;
                    end
                end
                PH_LOW:
                begin
                    if (cnt_inc >= {8'd0, lo_lim})
                    begin
                        count_next = 16'd0;
                        if (bit_reg != 3'd0)
                        begin
                            bit_next   = bit_reg - 3'd1;
                            phase_next = PH_HIGH;
                        end
                        else if (CW'(pix_cand) >= len)
                        begin
                            phase_next = PH_LATCH;
                            pix_next   = '0;
                            chan_next  = 2'd0;
                            bit_next   = 3'd7;
                        end
                        else
                        begin
                            pix_next   = pix_cand;
                            chan_next  = (chan_reg == 2'd2) ? 2'd0 : chan_reg + 2'd1;
                            bit_next   = 3'd7;
                            phase_next = PH_HIGH;
                            load_go    = 1'b1;
                        end
                    end
                    else
                    begin
                        count_next = cnt_inc;
                    end
                end
                PH_LATCH:
                begin
                    if (cnt_inc >= latch_lim)
                    begin
                        count_next = 16'd0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        count_next = cnt_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        stat.fill_go    = fill_go;
        stat.load_go    = load_go;
        stat.clear_last = (sweep_reg == AW'(MAX_LEDS - 1));
        stat.fill_last  = (CW'(sweep_reg) == len_m1);
    end

    // pixel store port selection
    assign ram_we    = cmd.clear_we || cmd.fill_we || (cmd.accept && wr_pixel);
    assign ram_waddr = (cmd.clear_we || cmd.fill_we) ? sweep_reg : idx_ext[AW-1:0];
    assign ram_raddr = pix_next[AW-1:0];

    always_comb
    begin
        if (cmd.clear_we)
        begin
            ram_wdata = '0;
        end
        else if (cmd.fill_we)
        begin
            ram_wdata = fill_color_reg;
        end
        else
        begin
            ram_wdata = {red, green, blue};
        end
    end

    als_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // grb channel select and scale by brightness / 255
    always_comb
    begin
        case (chan_reg)
            2'd0:    chan_val = ram_rdata[15:8];
            2'd1:    chan_val = ram_rdata[23:16];
            default: chan_val = ram_rdata[7:0];
        endcase
    end

    assign prod     = chan_val * bright_reg;
    assign quot_sum = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    assign scaled   = quot_sum[15:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg    <= RST_BRIGHTNESS;
            strip_reg     <= RST_STRIP_LENGTH;
            zero_high_reg <= RST_ZERO_HIGH;
            zero_low_reg  <= RST_ZERO_LOW;
            one_high_reg  <= RST_ONE_HIGH;
            one_low_reg   <= RST_ONE_LOW;
            latch_reg     <= RST_LATCH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BRIGHTNESS:   bright_reg    <= cfg_data[7:0];
                REG_STRIP_LENGTH: strip_reg     <= cfg_data[10:0];
                REG_ZERO_HIGH:    zero_high_reg <= cfg_data[7:0];
                REG_ZERO_LOW:     zero_low_reg  <= cfg_data[7:0];
                REG_ONE_HIGH:     one_high_reg  <= cfg_data[7:0];
                REG_ONE_LOW:      one_low_reg   <= cfg_data[7:0];
                REG_LATCH:        latch_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= 16'd0;
            bit_reg   <= 3'd7;
            chan_reg  <= 2'd0;
            pix_reg   <= '0;
            shift_reg <= 8'd0;
            sweep_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                bit_reg   <= bit_next;
                chan_reg  <= chan_next;
                pix_reg   <= pix_next;
            end
            if (cmd.load_byte)
            begin
                shift_reg <= scaled;
            end
            if (cmd.accept)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_inc)
            begin
                sweep_reg <= sweep_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            fill_color_reg <= {red, green, blue};
            line_reg       <= line;
            busy_reg       <= (phase_next != PH_IDLE) || done;
            done_reg       <= done;
        end
    end

    assign data_line  = line_reg;
    assign busy_res   = busy_reg;
    assign frame_done = done_reg;

endmodule

`default_nettype wire

[hdl/addressable_led_serializer_top.sv]
// a result is registered at its input transfer and offered as valid in the cycle after it
// ticks, pixel writes and idle commands keep the controller running; input stays ready while the output is free
// a start on a non-empty strip, and a tick that finishes a byte, pass through a load state (store read, then scale)
// a fill sweeps its colour over every pixel in use through the store write port before the next input is taken
// reset: a clearing pass over all MAX_LEDS store entries blacks the store before input is accepted
`default_nettype none

module addressable_led_serializer_top
    import als_pkg::*;
#(
    parameter int MAX_LEDS = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            action,
    input  wire logic [9:0]            pixel_index,
    input  wire logic [7:0]            red,
    input  wire logic [7:0]            green,
    input  wire logic [7:0]            blue,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       data_line,
    output logic                       busy_res,
    output logic                       frame_done
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    als_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    als_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .action      (action),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cmd         (cmd),
        .stat        (stat),
        .data_line   (data_line),
        .busy_res    (busy_res),
        .frame_done  (frame_done)
    );

endmodule

`default_nettype wire

[sim/tb_top.sv]
// self-checking testbench for the addressable led serializer with random flow control
`default_nettype none

module tb_top;
    import als_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_ITEMS = 400;

    typedef struct packed {
        logic line;
        logic busy;
        logic done;
    } line_sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            action = ACT_TICK;
    logic [9:0]            pixel_index = '0;
    logic [7:0]            red = '0;
    logic [7:0]            green = '0;
    logic [7:0]            blue = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  data_line;
    logic                  busy_res;
    logic                  frame_done;

    // predicted strip state and register copies
    logic [23:0]  color_store [STORE_DEPTH];
    int unsigned  ser_pixel;
    int unsigned  ser_channel;
    int unsigned  ser_bit;
    logic [7:0]   ser_byte;
    logic [1:0]   ser_phase;
    logic [15:0]  ser_count;
    logic [7:0]   cfg_bright;
    logic [10:0]  cfg_length;
    logic [7:0]   cfg_zero_high;
    logic [7:0]   cfg_zero_low;
    logic [7:0]   cfg_one_high;
    logic [7:0]   cfg_one_low;
    logic [15:0]  cfg_latch;

    line_sample_t pending_samples [$];
    int           idle_pct = 0;
    int           stall_pct = 0;
    logic         holding = 1'b0;
    event         hold_off_ev;
    int unsigned  items_sent = 0;
    int unsigned  samples_checked = 0;
    int unsigned  frames_done = 0;
    int unsigned  errors = 0;
    int           cycles = 0;

    addressable_led_serializer_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_line   (data_line),
        .busy_res    (busy_res),
        .frame_done  (frame_done)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("addressable_led_serializer_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= !holding && ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        forever
        begin
            @(hold_off_ev);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    function automatic void note_mismatch(string what, logic want, logic got);
        errors++;
        if (errors <= 40)
            $display("%0t: %s expected %b actual %b", $time, what, want, got);
    endfunction

    always @(posedge clk)
    begin
        line_sample_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: result with no transfer pending, expected none actual %b%b%b",
                             $time, data_line, busy_res, frame_done);
            end
            else
            begin
                want = pending_samples.pop_front();
                samples_checked++;
                if (data_line !== want.line)
                    note_mismatch("data_line", want.line, data_line);
                if (busy_res !== want.busy)
                    note_mismatch("busy_res", want.busy, busy_res);
                if (frame_done !== want.done)
                    note_mismatch("frame_done", want.done, frame_done);
            end
        end
    end

    function automatic int unsigned live_length();
        return (cfg_length > STORE_DEPTH) ? STORE_DEPTH : int'(cfg_length);
    endfunction

    function automatic int unsigned floor1(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic void load_channel_byte();
        logic [23:0] c;
        logic [7:0]  v;
        int unsigned prod;
        c = (ser_pixel < STORE_DEPTH) ? color_store[ser_pixel] : '0;
        case (ser_channel)
            0:       v = c[15:8];
            1:       v = c[23:16];
            default: v = c[7:0];
        endcase
        prod = 32'(v) * 32'(cfg_bright);
        ser_byte = 8'(prod / 255);
        ser_bit = 7;
    endfunction

    function automatic line_sample_t advance_strip(logic [1:0] act, logic [9:0] idx,
                                                   logic [7:0] r, logic [7:0] g, logic [7:0] b);
        line_sample_t s;
        int unsigned  len;
        int unsigned  lim;
        int unsigned  i;
        logic         cur;
        s = '0;
        len = live_length();
        if (act != ACT_TICK)
        begin
            if (ser_phase == PH_IDLE)
            begin
                if (act == ACT_WRITE)
                begin
                    if (idx < len)
                        color_store[idx] = {r, g, b};
                end
                else if (act == ACT_FILL)
                begin
                    for (i = 0; i < len; i++)
                        color_store[i] = {r, g, b};
                end
                else
                begin
                    ser_pixel = 0;
                    ser_channel = 0;
                    ser_count = '0;
                    if (len == 0)
                        ser_phase = PH_LATCH;
                    else
                    begin
                        load_channel_byte();
                        ser_phase = PH_HIGH;
                    end
                end
            end
            s.line = (ser_phase == PH_HIGH);
        end
        else if (ser_phase == PH_HIGH)
        begin
            cur = ser_byte[ser_bit];
            lim = floor1(cur ? cfg_one_high : cfg_zero_high);
            s.line = 1'b1;
            ser_count = ser_count + 16'd1;
            if (ser_count >= lim)
            begin
                ser_phase = PH_LOW;
                ser_count = '0;
            end
        end
        else if (ser_phase == PH_LOW)
        begin
            cur = ser_byte[ser_bit];
            lim = floor1(cur ? cfg_one_low : cfg_zero_low);
            ser_count = ser_count + 16'd1;
            if (ser_count >= lim)
            begin
                ser_count = '0;
                if (ser_bit > 0)
                begin
                    ser_bit--;
                    ser_phase = PH_HIGH;
                end
                else
                begin
                    ser_channel++;
                    if (ser_channel >= 3)
                    begin
                        ser_channel = 0;
                        ser_pixel++;
                    end
                    if (ser_pixel >= len)
                    begin
                        ser_phase = PH_LATCH;
                        ser_pixel = 0;
                        ser_channel = 0;
                        ser_bit = 7;
                    end
                    else
                    begin
                        load_channel_byte();
                        ser_phase = PH_HIGH;
                    end
                end
            end
        end
        else if (ser_phase == PH_LATCH)
        begin
            ser_count = ser_count + 16'd1;
            if (ser_count >= floor1(cfg_latch))
            begin
                ser_count = '0;
                ser_phase = PH_IDLE;
                s.done = 1'b1;
            end
        end
        s.busy = (ser_phase != PH_IDLE) || s.done;
        return s;
    endfunction

    function automatic void init_strip_model();
        foreach (color_store[i])
            color_store[i] = '0;
        ser_pixel = 0;
        ser_channel = 0;
        ser_bit = 7;
        ser_byte = '0;
        ser_phase = PH_IDLE;
        ser_count = '0;
        cfg_bright = RST_BRIGHTNESS;
        cfg_length = RST_STRIP_LENGTH;
        cfg_zero_high = RST_ZERO_HIGH;
        cfg_zero_low = RST_ZERO_LOW;
        cfg_one_high = RST_ONE_HIGH;
        cfg_one_low = RST_ONE_LOW;
        cfg_latch = RST_LATCH;
    endfunction

    // valid stays up after a transfer; a gap or settle lowers it
    task automatic send_item(logic [1:0] act, logic [9:0] idx,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
        line_sample_t s;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        pixel_index <= idx;
        red <= r;
        green <= g;
        blue <= b;
        do @(posedge clk); while (!in_ready);
        s = advance_strip(act, idx, r, g, b);
        pending_samples.push_back(s);
        items_sent++;
        if (s.done)
            frames_done++;
    endtask

    task automatic send_rand(logic [1:0] act);
        send_item(act, 10'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic run_frame();
        while (ser_phase != PH_IDLE)
            send_rand(ACT_TICK);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        while (!in_ready) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_BRIGHTNESS:   cfg_bright = value[7:0];
            REG_STRIP_LENGTH: cfg_length = value[10:0];
            REG_ZERO_HIGH:    cfg_zero_high = value[7:0];
            REG_ZERO_LOW:     cfg_zero_low = value[7:0];
            REG_ONE_HIGH:     cfg_one_high = value[7:0];
            REG_ONE_LOW:      cfg_one_low = value[7:0];
            REG_LATCH:        cfg_latch = value;
            default:          ;
        endcase
    endtask

    task automatic program_strip(logic [7:0] bright, logic [10:0] len,
                                 logic [7:0] zh, logic [7:0] zl,
                                 logic [7:0] oh, logic [7:0] ol, logic [15:0] latch);
        settle();
        write_reg(REG_BRIGHTNESS, 16'(bright));
        write_reg(REG_STRIP_LENGTH, 16'(len));
        write_reg(REG_ZERO_HIGH, 16'(zh));
        write_reg(REG_ZERO_LOW, 16'(zl));
        write_reg(REG_ONE_HIGH, 16'(oh));
        write_reg(REG_ONE_LOW, 16'(ol));
        write_reg(REG_LATCH, latch);
        cfg_we <= 1'b0;
    endtask

    task automatic test_idle_commands();
        send_rand(ACT_TICK);
        send_item(ACT_WRITE, 10'd0, 8'hff, 8'hff, 8'hff);
        send_item(ACT_WRITE, 10'd1023, 8'ha5, 8'h5a, 8'hc3);
        send_item(ACT_FILL, 10'd0, 8'h00, 8'hff, 8'h00);
        send_item(ACT_WRITE, 10'd0, 8'h00, 8'h00, 8'h00);
        send_rand(ACT_TICK);
    endtask

    task automatic test_frame_basics();
        program_strip(8'd255, 11'd4, 8'd1, 8'd2, 8'd2, 8'd1, 16'd3);
        send_item(ACT_WRITE, 10'd0, 8'hff, 8'h00, 8'h80);
        send_item(ACT_WRITE, 10'd3, 8'h01, 8'hfe, 8'h7f);
        send_item(ACT_WRITE, 10'd4, 8'h11, 8'h22, 8'h33);
        send_item(ACT_WRITE, 10'd1023, 8'hff, 8'hff, 8'hff);
        send_rand(ACT_START);
        repeat (5) send_rand(ACT_TICK);
        // commands during a frame must not disturb it
        send_item(ACT_WRITE, 10'd1, 8'hff, 8'hff, 8'hff);
        send_rand(ACT_FILL);
        send_rand(ACT_START);
        run_frame();
        program_strip(8'd128, 11'd4, 8'd2, 8'd1, 8'd1, 8'd2, 16'd2);
        send_rand(ACT_START);
        run_frame();
        program_strip(8'd0, 11'd2, 8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
        send_item(ACT_FILL, 10'd0, 8'hff, 8'hff, 8'hff);
        send_rand(ACT_START);
        run_frame();
    endtask

    task automatic test_special_lengths();
        program_strip(8'd255, 11'd0, 8'd1, 8'd1, 8'd1, 8'd1, 16'd5);
        send_item(ACT_WRITE, 10'd0, 8'h12, 8'h34, 8'h56);
        send_item(ACT_FILL, 10'd0, 8'h65, 8'h43, 8'h21);
        send_rand(ACT_START);
        run_frame();
        program_strip(8'd255, 11'd1, 8'd1, 8'd1, 8'd1, 8'd1, 16'd2);
        send_rand(ACT_START);
        run_frame();
    endtask

    task automatic test_zero_timing();
        program_strip(8'd255, 11'd1, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        send_item(ACT_WRITE, 10'd0, 8'h96, 8'h69, 8'hc3);
        send_rand(ACT_START);
        run_frame();
    endtask

    task automatic test_live_registers();
        program_strip(8'd255, 11'd2, 8'd2, 8'd2, 8'd2, 8'd2, 16'd4);
        send_item(ACT_WRITE, 10'd0, 8'hf0, 8'h0f, 8'hcc);
        send_item(ACT_WRITE, 10'd1, 8'h33, 8'haa, 8'h55);
        send_rand(ACT_START);
        repeat (20) send_rand(ACT_TICK);
        // new timing, scale and a shorter strip take effect mid-frame
        program_strip(8'd100, 11'd1, 8'd3, 8'd1, 8'd1, 8'd3, 16'd2);
        run_frame();
        program_strip(8'd255, 11'd3, 8'd1, 8'd1, 8'd1, 8'd1, 16'd2);
        send_rand(ACT_START);
        repeat (60) send_rand(ACT_TICK);
        program_strip(8'd77, 11'd3, 8'd2, 8'd3, 8'd3, 8'd2, 16'd7);
        run_frame();
    endtask

    task automatic test_long_strip();
        program_strip(8'd255, 11'd1024, 8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
        send_rand(ACT_FILL);
        send_item(ACT_WRITE, 10'd1023, 8'hff, 8'hff, 8'hff);
        send_rand(ACT_WRITE);
        // lengths past the store size count as a full store
        program_strip(8'd255, 11'd2047, 8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
        send_item(ACT_WRITE, 10'd1022, 8'h00, 8'h00, 8'h00);
        send_rand(ACT_START);
        run_frame();
    endtask

    task automatic test_slow_timing();
        program_strip(8'd255, 11'd1, 8'd255, 8'd255, 8'd255, 8'd255, 16'hffff);
        send_item(ACT_WRITE, 10'd0, 8'haa, 8'h55, 8'hf0);
        send_rand(ACT_START);
        run_frame();
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        program_strip(8'd200, 11'd2, 8'd1, 8'd2, 8'd2, 8'd1, 16'd4);
        send_rand(ACT_WRITE);
        send_item(ACT_WRITE, 10'd1, 8'h81, 8'h42, 8'h24);
        -> hold_off_ev;
        send_rand(ACT_START);
        run_frame();
    endtask

    task automatic test_random_traffic(int idle, int stall);
        int unsigned stop_at;
        int unsigned len;
        logic [9:0]  idx;
        idle_pct = idle;
        stall_pct = stall;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 75)
            begin
                program_strip(($urandom_range(3) == 0) ? 8'd255 : 8'($urandom),
                              ($urandom_range(19) == 0) ? 11'd0 : 11'($urandom_range(1, 3)),
                              8'($urandom_range(0, 3)), 8'($urandom_range(1, 3)),
                              8'($urandom_range(1, 3)), 8'($urandom_range(0, 3)),
                              16'($urandom_range(1, 6)));
                len = live_length();
                repeat ($urandom_range(0, 3))
                begin
                    if (len != 0 && $urandom_range(1) == 0)
                        idx = 10'($urandom_range(0, len - 1));
                    else
                        idx = 10'($urandom);
                    send_item(ACT_WRITE, idx, 8'($urandom), 8'($urandom), 8'($urandom));
                end
                if ($urandom_range(3) == 0)
                    send_rand(ACT_FILL);
                send_rand(ACT_START);
                while (ser_phase != PH_IDLE)
                begin
                    if ($urandom_range(19) == 0)
                        send_rand(2'($urandom_range(0, 2)));
                    else
                        send_rand(ACT_TICK);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    send_rand(2'($urandom_range(0, 3)));
            end
        end
    endtask

    initial
    begin
        init_strip_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_commands();
        test_frame_basics();
        test_special_lengths();
        test_zero_timing();
        test_live_registers();
        test_long_strip();
        test_slow_timing();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(61, 0);
        test_random_traffic(0, 61);
        test_random_traffic(37, 37);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("run covered %0d transfers in, %0d results checked, %0d frames completed",
                 items_sent, samples_checked, frames_done);
        $display("flow control: free running, sender gaps, receiver stalls, both, long hold-off");
        if (errors == 0)
            $display("addressable_led_serializer_top test passed");
        else
            $display("addressable_led_serializer_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
